// ===== sv/lmtc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmtc_pkg
// Shared types and timing constants for the LCD mode timing controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lmtc_pkg;

  // Display modes as reported on the result channel
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LCD_ENABLE   = 2'd0,
    CFG_LINE_COMPARE = 2'd1,
    CFG_STAT_IRQ_EN  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  // Bit positions in the stat interrupt enable register
  localparam int unsigned IRQ_EN_HBLANK = 0;
  localparam int unsigned IRQ_EN_VBLANK = 1;
  localparam int unsigned IRQ_EN_OAM    = 2;
  localparam int unsigned IRQ_EN_COINC  = 3;

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned LINE_W = 8;

  // Mode durations in machine cycles
  localparam logic [CNT_W-1:0] OAM_CYCLES      = CNT_W'(80);
  localparam logic [CNT_W-1:0] TRANSFER_CYCLES = CNT_W'(172);
  localparam logic [CNT_W-1:0] HBLANK_CYCLES   = CNT_W'(204);
  localparam logic [CNT_W-1:0] LINE_CYCLES     = CNT_W'(456);

  // Line numbering
  localparam int unsigned        LINES_PER_FRAME   = 154;
  localparam logic [LINE_W-1:0]  LAST_LINE         = LINE_W'(LINES_PER_FRAME - 1);
  localparam logic [LINE_W-1:0]  FIRST_VBLANK_LINE = LINE_W'(144);

endpackage : lmtc_pkg

`default_nettype wire

// ===== sv/lcd_mode_timing_controller_unit.sv =====
// ----------------------------------------------------------------------------
// lcd_mode_timing_controller_unit
// LCD mode sequencer: accumulates elapsed cycles, steps through OAM search,
// pixel transfer, hblank and vblank, tracks the scanline and raises
// interrupt requests and event pulses.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | direction | handshake
//  --------+----------------------------------------+-----------+-------------
//  in      | in_cycles, in_clear_line               | sink      | valid/ready
//  out     | out_mode .. out_oam_scan_start         | source    | valid/ready
//  cfg     | cfg_index, cfg_data                    | sink      | valid/ready
//
//  One item per cycle while out is not stalled. The mode state and the result
//  register are both loaded at the edge that accepts the item.
//  in_ready is high while the result register is empty or being drained, so
//  a stall on out holds exactly one result and blocks further input.
//  cfg_ready is always high. Synchronous active-low reset puts the block in
//  vblank, line 0, counter 0, coincidence set, configuration and out_valid cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_mode_timing_controller_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input items
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_cycles,
  input  wire logic                      in_clear_line,
  // result items
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [1:0]                     out_mode,
  output logic [lmtc_pkg::LINE_W-1:0]    out_line,
  output logic                           out_coincidence,
  output logic                           out_vblank_request,
  output logic                           out_stat_request,
  output logic                           out_frame_done,
  output logic                           out_draw_line,
  output logic                           out_oam_scan_start,
  // configuration writes
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [7:0]                cfg_data
);

  import lmtc_pkg::*;

  // Configuration registers
  logic              lcd_enable_r;
  logic [LINE_W-1:0] line_compare_r;
  logic [3:0]        irq_en_r;

  // Timing state
  lcd_mode_t         mode_r,  mode_nxt;
  logic [LINE_W-1:0] line_r,  line_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic              coin_r,  coin_nxt;

  // Result register
  logic              out_valid_r;
  lcd_mode_t         o_mode_r;
  logic [LINE_W-1:0] o_line_r;
  logic              o_coin_r, o_vbl_r, o_stat_r, o_frame_r, o_draw_r, o_oams_r;

  // Step outputs
  logic vbl_nxt, stat_nxt, frame_nxt, draw_nxt, oams_nxt;

  // Intermediates
  logic              in_fire;
  logic [LINE_W-1:0] line_base, line_adv;
  logic              adv_hit, adv_stat;
  logic [CNT_W:0]    cnt_sum;
  logic [CNT_W-1:0]  cnt_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;

  // Line bookkeeping: optional clear, then the candidate next line
  assign line_base = in_clear_line ? '0 : line_r;
  assign line_adv  = (line_base == LAST_LINE) ? '0 : line_base + LINE_W'(1);
  assign adv_hit   = (line_adv == line_compare_r);
  assign adv_stat  = adv_hit & irq_en_r[IRQ_EN_COINC];

  // Saturating cycle accumulation
  assign cnt_sum = {1'b0, cnt_r} + {{(CNT_W-7){1'b0}}, in_cycles};
  assign cnt_sat = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];

  // Mode step: at most one advance per item
  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_base;
    coin_nxt  = coin_r;
    cnt_nxt   = cnt_sat;
    vbl_nxt   = 1'b0;
    stat_nxt  = 1'b0;
    frame_nxt = 1'b0;
    draw_nxt  = 1'b0;
    oams_nxt  = 1'b0;
    if (!lcd_enable_r) begin
      cnt_nxt  = '0;
      mode_nxt = MODE_HBLANK;
    end else begin
      unique case (mode_r)
        MODE_HBLANK: begin
          if (cnt_sat >= HBLANK_CYCLES) begin
            draw_nxt = 1'b1;
            cnt_nxt  = cnt_sat - HBLANK_CYCLES;
            line_nxt = line_adv;
            coin_nxt = adv_hit;
            if (line_adv == FIRST_VBLANK_LINE) begin
              mode_nxt = MODE_VBLANK;
              vbl_nxt  = 1'b1;
              stat_nxt = adv_stat | irq_en_r[IRQ_EN_VBLANK];
            end else begin
              mode_nxt = MODE_OAM;
              oams_nxt = 1'b1;
              stat_nxt = adv_stat | irq_en_r[IRQ_EN_OAM];
            end
          end
        end
        MODE_VBLANK: begin
          if (cnt_sat >= LINE_CYCLES) begin
            cnt_nxt  = cnt_sat - LINE_CYCLES;
            line_nxt = line_adv;
            coin_nxt = adv_hit;
            stat_nxt = adv_stat;
            if (line_adv == '0) begin
              frame_nxt = 1'b1;
              mode_nxt  = MODE_OAM;
              oams_nxt  = 1'b1;
              stat_nxt  = adv_stat | irq_en_r[IRQ_EN_OAM];
            end
          end
        end
        MODE_OAM: begin
          if (cnt_sat >= OAM_CYCLES) begin
            cnt_nxt  = cnt_sat - OAM_CYCLES;
            mode_nxt = MODE_XFER;
          end
        end
        MODE_XFER: begin
          if (cnt_sat >= TRANSFER_CYCLES) begin
            cnt_nxt  = cnt_sat - TRANSFER_CYCLES;
            mode_nxt = MODE_HBLANK;
            stat_nxt = irq_en_r[IRQ_EN_HBLANK];
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_enable_r   <= 1'b0;
      line_compare_r <= '0;
      irq_en_r       <= '0;
      mode_r         <= MODE_VBLANK;
      line_r         <= '0;
      cnt_r          <= '0;
      coin_r         <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LCD_ENABLE:   lcd_enable_r   <= cfg_data[0];
          CFG_LINE_COMPARE: line_compare_r <= cfg_data;
          CFG_STAT_IRQ_EN:  irq_en_r       <= cfg_data[3:0];
          default:          lcd_enable_r   <= lcd_enable_r;
        endcase
      end
      if (in_fire) begin
        mode_r <= mode_nxt;
        line_r <= line_nxt;
        cnt_r  <= cnt_nxt;
        coin_r <= coin_nxt;
      end
      out_valid_r <= in_fire | (out_valid_r & ~out_ready);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      o_mode_r  <= mode_nxt;
      o_line_r  <= line_nxt;
      o_coin_r  <= coin_nxt;
      o_vbl_r   <= vbl_nxt;
      o_stat_r  <= stat_nxt;
      o_frame_r <= frame_nxt;
      o_draw_r  <= draw_nxt;
      o_oams_r  <= oams_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode           = o_mode_r;
  assign out_line           = o_line_r;
  assign out_coincidence    = o_coin_r;
  assign out_vblank_request = o_vbl_r;
  assign out_stat_request   = o_stat_r;
  assign out_frame_done     = o_frame_r;
  assign out_draw_line      = o_draw_r;
  assign out_oam_scan_start = o_oams_r;

endmodule : lcd_mode_timing_controller_unit

`default_nettype wire

// ===== tb/tb_lcd_mode_timing_controller_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lcd_mode_timing_controller_unit
// Self-checking bench for the LCD mode sequencer. A queue-fed driver sends
// cycle ticks and a monitor predicts each status item from a local model of
// the mode, line and counter state, then compares it field by field.
// Register writes happen only once the block has drained.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lmtc_pkg::*;

  // Mode durations and line numbering of the display timing
  localparam logic [15:0] OAM_LEN      = 16'd80;
  localparam logic [15:0] XFER_LEN     = 16'd172;
  localparam logic [15:0] HBLANK_LEN   = 16'd204;
  localparam logic [15:0] LINE_LEN     = 16'd456;
  localparam logic [7:0]  FIRST_VBLANK = 8'd144;
  localparam logic [7:0]  TOP_LINE     = 8'd153;
  localparam int          STALL_LIMIT  = 1000;

  typedef struct packed {
    logic [7:0] cycles;
    logic       clear_line;
  } tick_t;

  typedef struct packed {
    lcd_mode_t  mode;
    logic [7:0] line;
    logic       coinc;
    logic       vblank_req;
    logic       stat_req;
    logic       frame_done;
    logic       draw_line;
    logic       oam_start;
  } lcd_status_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_cycles = 8'd0;
  logic       in_clear_line = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_mode;
  logic [7:0] out_line;
  logic       out_coincidence;
  logic       out_vblank_request;
  logic       out_stat_request;
  logic       out_frame_done;
  logic       out_draw_line;
  logic       out_oam_scan_start;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'd0;

  lcd_mode_timing_controller_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cycles          (in_cycles),
    .in_clear_line      (in_clear_line),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_mode           (out_mode),
    .out_line           (out_line),
    .out_coincidence    (out_coincidence),
    .out_vblank_request (out_vblank_request),
    .out_stat_request   (out_stat_request),
    .out_frame_done     (out_frame_done),
    .out_draw_line      (out_draw_line),
    .out_oam_scan_start (out_oam_scan_start),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Local timing state and register copies
  lcd_mode_t   pred_mode;
  logic [7:0]  pred_line;
  logic [15:0] pred_count;
  logic        pred_coinc;
  logic        cfg_lcd_on;
  logic [7:0]  cfg_line_cmp;
  logic [3:0]  cfg_irq_en;

  tick_t       tick_queue[$];
  lcd_status_t status_due[$];
  tick_t       next_tick;
  logic        in_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic        no_gaps = 1'b0;
  int          quiet_cycles = 0;
  int          mismatches = 0;
  int          n_ticks = 0, n_lit = 0, n_results = 0, n_writes = 0;
  int          n_frames = 0, n_vblank = 0, n_stat = 0, n_coinc = 0, n_draw = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Step the line counter modulo a frame; returns the coincidence stat request
  function automatic logic bump_scanline();
    pred_line  = (pred_line >= TOP_LINE) ? 8'd0 : pred_line + 8'd1;
    pred_coinc = (pred_line == cfg_line_cmp);
    return pred_coinc & cfg_irq_en[IRQ_EN_COINC];
  endfunction

  // Apply one tick to the local state and build the status it should produce
  function automatic lcd_status_t predict_tick(input tick_t t);
    lcd_status_t r;
    logic [16:0] sum;
    r = '0;
    if (t.clear_line) pred_line = 8'd0;
    if (!cfg_lcd_on) begin
      pred_count = 16'd0;
      pred_mode  = MODE_HBLANK;
    end else begin
      sum = {1'b0, pred_count} + {9'd0, t.cycles};
      pred_count = (sum > 17'h0FFFF) ? 16'hFFFF : sum[15:0];
      case (pred_mode)
        MODE_HBLANK: begin
          if (pred_count >= HBLANK_LEN) begin
            r.draw_line = 1'b1;
            pred_count -= HBLANK_LEN;
            r.stat_req |= bump_scanline();
            if (pred_line == FIRST_VBLANK) begin
              pred_mode    = MODE_VBLANK;
              r.vblank_req = 1'b1;
              r.stat_req  |= cfg_irq_en[IRQ_EN_VBLANK];
            end else begin
              pred_mode   = MODE_OAM;
              r.oam_start = 1'b1;
              r.stat_req |= cfg_irq_en[IRQ_EN_OAM];
            end
          end
        end
        MODE_VBLANK: begin
          if (pred_count >= LINE_LEN) begin
            pred_count -= LINE_LEN;
            r.stat_req |= bump_scanline();
            // wrap to line 0 closes the frame
            if (pred_line == 8'd0) begin
              r.frame_done = 1'b1;
              pred_mode    = MODE_OAM;
              r.oam_start  = 1'b1;
              r.stat_req  |= cfg_irq_en[IRQ_EN_OAM];
            end
          end
        end
        MODE_OAM: begin
          if (pred_count >= OAM_LEN) begin
            pred_count -= OAM_LEN;
            pred_mode   = MODE_XFER;
          end
        end
        default: begin
          if (pred_count >= XFER_LEN) begin
            pred_count -= XFER_LEN;
            pred_mode   = MODE_HBLANK;
            r.stat_req |= cfg_irq_en[IRQ_EN_HBLANK];
          end
        end
      endcase
    end
    r.mode  = pred_mode;
    r.line  = pred_line;
    r.coinc = pred_coinc;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Driver: holds an item until taken, otherwise pulls the next one or idles
  always @(negedge clk) begin
    out_ready <= no_gaps || ($urandom_range(0, 99) >= 17);
    if (!(in_valid && !in_taken)) begin
      if (tick_queue.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 17)) begin
        next_tick = tick_queue.pop_front();
        in_valid      <= 1'b1;
        in_cycles     <= next_tick.cycles;
        in_clear_line <= next_tick.clear_line;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks results, predicts accepted ticks, tracks register writes
  always @(posedge clk) begin
    lcd_status_t want;
    in_taken  = 1'b0;
    cfg_taken = 1'b0;
    if (!rst_n) begin
      pred_mode    = MODE_VBLANK;
      pred_line    = 8'd0;
      pred_count   = 16'd0;
      pred_coinc   = 1'b1;
      cfg_lcd_on   = 1'b0;
      cfg_line_cmp = 8'd0;
      cfg_irq_en   = 4'd0;
      quiet_cycles++;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (status_due.size() == 0) begin
          flag_mismatch("unexpected result", 1, 0);
        end else begin
          want = status_due.pop_front();
          if (out_mode !== want.mode) flag_mismatch("mode", out_mode, want.mode);
          if (out_line !== want.line) flag_mismatch("line", out_line, want.line);
          if (out_coincidence !== want.coinc)
            flag_mismatch("coincidence", out_coincidence, want.coinc);
          if (out_vblank_request !== want.vblank_req)
            flag_mismatch("vblank_request", out_vblank_request, want.vblank_req);
          if (out_stat_request !== want.stat_req)
            flag_mismatch("stat_request", out_stat_request, want.stat_req);
          if (out_frame_done !== want.frame_done)
            flag_mismatch("frame_done", out_frame_done, want.frame_done);
          if (out_draw_line !== want.draw_line)
            flag_mismatch("draw_line", out_draw_line, want.draw_line);
          if (out_oam_scan_start !== want.oam_start)
            flag_mismatch("oam_scan_start", out_oam_scan_start, want.oam_start);
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        n_ticks++;
        if (cfg_lcd_on) n_lit++;
        want = predict_tick('{cycles: in_cycles, clear_line: in_clear_line});
        n_frames += want.frame_done;
        n_vblank += want.vblank_req;
        n_stat   += want.stat_req;
        n_draw   += want.draw_line;
        n_coinc  += (want.coinc && (want.draw_line || want.frame_done || want.mode == MODE_VBLANK));
        status_due.insert(status_due.size(), want);
      end
      if (cfg_valid && cfg_ready) begin
        cfg_taken = 1'b1;
        n_writes++;
        case (cfg_index)
          CFG_LCD_ENABLE:   cfg_lcd_on   = cfg_data[0];
          CFG_LINE_COMPARE: cfg_line_cmp = cfg_data;
          CFG_STAT_IRQ_EN:  cfg_irq_en   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_taken || cfg_taken || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Watchdog on handshake progress
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Checks at rising edges, where the driver's state is settled; returns at a
  // falling edge once nothing is in flight
  task automatic wait_drained();
    do @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || status_due.size() != 0);
    @(negedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk);
    while (!cfg_taken);
  endtask

  // Drain, write all registers (junk in unused data bits), return at a rising edge
  task automatic load_regs(input logic on, input logic [7:0] cmp, input logic [3:0] irq);
    wait_drained();
    put_reg(CFG_LCD_ENABLE, {7'($urandom), on});
    put_reg(CFG_LINE_COMPARE, cmp);
    put_reg(CFG_STAT_IRQ_EN, {4'($urandom), irq});
    if ($urandom_range(0, 3) == 0) put_reg(CFG_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_tick(input logic [7:0] cyc, input logic clr);
    tick_queue.insert(tick_queue.size(), '{cycles: cyc, clear_line: clr});
  endtask

  // Stimulus
  initial begin
    tick_t      t;
    int         k, n, lit_ticks, pick;
    logic       on;
    logic [7:0] cmp;
    logic [3:0] irq;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // vblank at line 0 straight out of reset, then a line clear
    load_regs(1'b1, 8'd1, 4'hF);
    add_tick(8'd255, 1'b0); add_tick(8'd255, 1'b0); add_tick(8'd0, 1'b0);
    add_tick(8'd255, 1'b1); add_tick(8'd201, 1'b0); add_tick(8'd255, 1'b0);

    // display off: counter cleared, forced hblank, clear still applies
    load_regs(1'b0, 8'd0, 4'h0);
    add_tick(8'd0, 1'b0); add_tick(8'd255, 1'b1); add_tick(8'd99, 1'b0);

    // exact mode boundaries from hblank through OAM and transfer
    load_regs(1'b1, 8'd1, 4'hF);
    add_tick(8'd204, 1'b0); add_tick(8'd79, 1'b0); add_tick(8'd1, 1'b0);
    add_tick(8'd171, 1'b0); add_tick(8'd1, 1'b0); add_tick(8'd203, 1'b0);
    add_tick(8'd1, 1'b0); add_tick(8'd80, 1'b0); add_tick(8'd172, 1'b1);
    add_tick(8'd255, 1'b0); add_tick(8'd255, 1'b0); add_tick(8'd255, 1'b0);
    add_tick(8'd0, 1'b0); add_tick(8'd128, 1'b0);

    // back-to-back maximum ticks: the counter builds a large backlog
    load_regs(1'b1, 8'd153, 4'hA);
    no_gaps = 1'b1;
    repeat (150) add_tick(8'd255, 1'b0);

    // random phases; the first one starts with the display off
    k = 0;
    lit_ticks = 0;
    while (lit_ticks < 200) begin
      on = (k == 0) ? 1'b0 : ($urandom_range(0, 5) != 0);
      case (k)
        0:       cmp = 8'd0;
        1:       cmp = 8'd255;
        2:       cmp = 8'd153;
        3:       cmp = 8'd154;
        default: cmp = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, 153));
      endcase
      irq = (k == 1) ? 4'h0 : (k == 2) ? 4'hF : 4'($urandom);
      load_regs(on, cmp, irq);
      no_gaps = 1'b0;
      n = on ? $urandom_range(30, 70) : 6;
      repeat (n) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)     t.cycles = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        else if (pick < 4) t.cycles = 8'($urandom);
        else               t.cycles = 8'($urandom_range(150, 255));
        t.clear_line = ($urandom_range(0, 39) == 0);
        tick_queue.insert(tick_queue.size(), t);
      end
      if (on) lit_ticks += n;
      k++;
    end

    wait_drained();
    repeat (4) @(negedge clk);
    $display("ran %0d ticks (%0d with display on) over %0d register writes",
             n_ticks, n_lit, n_writes);
    $display("saw %0d frames, %0d vblank and %0d stat requests, %0d line draws, %0d compare hits",
             n_frames, n_vblank, n_stat, n_draw, n_coinc);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lmtc_pkg.sv
sv/lcd_mode_timing_controller_unit.sv
tb/tb_lcd_mode_timing_controller_unit.sv
